// File: rtl/box_filter_3x3_rgb_top_macros.svh
// Assertion macros used by the box filter top level.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef BOX_FILTER_3X3_RGB_TOP_MACROS_SVH
`define BOX_FILTER_3X3_RGB_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define BFR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bfr_pkg.sv
// Shared types and constants for the 3x3 box filter.
// No dependencies; imported by bfr_front, bfr_back and the top level.
package bfr_pkg;

  // Pixel format: three 8-bit channels packed {red, green, blue}
  localparam int NUM_CH = 3;
  localparam int PIX_W  = 8;
  localparam int RGB_W  = NUM_CH * PIX_W;

  // Column sum of three samples and full 3x3 sum
  localparam int CSUM_W = 10;
  localparam int SUM_W  = 12;

  // floor(s / 9) for s <= 2295 as (s * 7282) >> 16
  localparam int RECIP_W = 13;
  localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
  localparam int DIV9_SHIFT = 16;

  // Configuration registers
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  // Request opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Entries in the front-to-back queue
  localparam int QUEUE_DEPTH = 4;

  // Per-request classification made by the front end
  typedef struct packed {
    logic emit;      // request releases one output pixel
    logic interior;  // that output gets the 3x3 mean
    logic last;      // that output closes the frame
  } bfr_flags_t;

  // Front-end status for checking
  typedef struct packed {
    logic draining;    // all pixels of the frame are in
    logic frame_done;  // request carrying frame_last was queued
  } bfr_front_stat_t;

endpackage

// File: rtl/bfr_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read returns the old contents on a same-address write. No dependencies.
module bfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bfr_fifo.sv
// Small flop-based queue between the front end and the filter back end.
// No dependencies.
module bfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic push, pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/bfr_front.sv
// Front end of the box filter: config registers, raster counters, and
// classification of each request. Depends on bfr_pkg.
module bfr_front
  import bfr_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [PIX_W-1:0]      in_blue,
  input  logic [PIX_W-1:0]      in_green,
  input  logic [PIX_W-1:0]      in_red,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // classified requests to the queue
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic [RGB_W-1:0]      q_px,
  output logic [COL_W-1:0]      q_col,
  output bfr_flags_t            q_flags,
  output bfr_front_stat_t       stat
);

  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int W_RST  = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam int H_RST  = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

  logic [WD_W-1:0]   w_eff_r;
  logic [HD_W-1:0]   h_eff_r;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;
  logic [31:0]       w_clamp, h_clamp;
  logic cfg_we, cfg_hit, draining, push, emit, interior, last, in_wrap, out_wrap;

  // Config port never stalls
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_we
                     && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  // Clamp written dimensions to 1..MAX
  always_comb begin
    w_clamp = 32'(cfg_data[FW_W-1:0]);
    h_clamp = 32'(cfg_data[FH_W-1:0]);
    if (w_clamp == 32'd0) begin
      w_clamp = 32'd1;
    end else if (w_clamp > 32'(MAX_WIDTH)) begin
      w_clamp = 32'(MAX_WIDTH);
    end
    if (h_clamp == 32'd0) begin
      h_clamp = 32'd1;
    end else if (h_clamp > 32'(MAX_HEIGHT)) begin
      h_clamp = 32'(MAX_HEIGHT);
    end
  end

  // Classification of the request at the port
  assign draining = 32'(in_row_r) >= 32'(h_eff_r);
  assign in_ready = q_ready;
  assign push     = in_valid && in_ready && (draining || in_opcode == OP_PIXEL);
  // input position n >= W+1
  assign emit     = (in_row_r >= ROW_W'(2)) || (in_row_r == ROW_W'(1) && in_col_r != '0);
  assign interior = (out_row_r != '0) && (32'(out_row_r) + 32'd2 <= 32'(h_eff_r))
                    && (out_col_r != '0) && (32'(out_col_r) + 32'd2 <= 32'(w_eff_r));
  assign last     = (32'(out_row_r) + 32'd1 >= 32'(h_eff_r))
                    && (32'(out_col_r) + 32'd1 >= 32'(w_eff_r));
  assign in_wrap  = 32'(in_col_r) + 32'd1 >= 32'(w_eff_r);
  assign out_wrap = 32'(out_col_r) + 32'd1 >= 32'(w_eff_r);

  assign q_valid  = push;
  assign q_px     = draining ? '0 : {in_red, in_green, in_blue};
  assign q_col    = in_col_r;
  assign q_flags  = '{emit: emit, interior: interior, last: last};

  assign stat.draining   = draining;
  assign stat.frame_done = push && emit && last;

  // Raster counters
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_hit) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (push) begin
      if (in_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (emit) begin
        if (last) begin
          // frame closed: next frame starts with an empty window
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + OROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r   <= WD_W'(W_RST);
      h_eff_r   <= HD_W'(H_RST);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_FRAME_WIDTH) begin
        w_eff_r <= w_clamp[WD_W-1:0];
      end
      if (cfg_we && cfg_index == REG_FRAME_HEIGHT) begin
        h_eff_r <= h_clamp[HD_W-1:0];
      end
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

// File: rtl/bfr_back.sv
// Back end of the box filter: line store, window, 3x3 sum, divide by 9,
// output register. Depends on bfr_pkg and bfr_ram.
module bfr_back
  import bfr_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  // classified requests from the queue
  input  logic               q_valid,
  output logic               q_ready,
  input  logic [RGB_W-1:0]   q_px,
  input  logic [COL_W-1:0]   q_col,
  input  bfr_flags_t         q_flags,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_blue,
  output logic [PIX_W-1:0]   out_green,
  output logic [PIX_W-1:0]   out_red,
  output logic               out_last
);

  localparam int WORD_W = 2 * RGB_W;  // {upper, middle}
  localparam int PROD_W = SUM_W + RECIP_W;

  // stage 1: line store read pending
  logic                   s1_valid_r;
  logic [RGB_W-1:0]       s1_px_r;
  logic [COL_W-1:0]       s1_col_r;
  bfr_flags_t             s1_flags_r;
  logic                   byp_r;
  logic [WORD_W-1:0]      byp_word_r;
  logic [WORD_W-1:0]      ram_rdata, cur_word, wr_word;
  logic [RGB_W-1:0]       up_px, mid_px;
  // window: column sums of the two newest columns, middle pixel of newest
  logic [NUM_CH*CSUM_W-1:0] cs_new, cs1_r, cs2_r;
  logic [RGB_W-1:0]         c2mid_r;
  // stage 2: three column sums
  logic                     s2_valid_r;
  logic [NUM_CH*CSUM_W-1:0] s2_cs0_r, s2_cs1_r, s2_cs2_r;
  logic [RGB_W-1:0]         s2_ctr_r;
  logic                     s2_int_r, s2_last_r;
  // stage 3: full sums
  logic                     s3_valid_r;
  logic [NUM_CH*SUM_W-1:0]  sum_all, s3_sum_r;
  logic [RGB_W-1:0]         s3_ctr_r;
  logic                     s3_int_r, s3_last_r;
  // output register
  logic                     out_valid_r;
  logic [RGB_W-1:0]         out_px_r, mean_px, out_px_nxt;
  logic                     out_last_r;
  logic out_en, s3_free, s2_free, s1_go, pop;

  // Pipeline flow control
  assign out_en  = !out_valid_r || out_ready;
  assign s3_free = !s3_valid_r || out_en;
  assign s2_free = !s2_valid_r || s3_free;
  assign s1_go   = s1_valid_r && (s2_free || !s1_flags_r.emit);
  assign q_ready = !s1_valid_r || s1_go;
  assign pop     = q_valid && q_ready;

  // Two line stores in one word: read at pop, write back when stage 1 leaves
  bfr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata (wr_word),
    .re    (pop),
    .raddr (q_col),
    .rdata (ram_rdata)
  );

  // Same-column write in the read cycle (one-pixel rows) is forwarded
  assign cur_word = byp_r ? byp_word_r : ram_rdata;
  assign up_px    = cur_word[WORD_W-1:RGB_W];
  assign mid_px   = cur_word[RGB_W-1:0];
  assign wr_word  = {mid_px, s1_px_r};

  // Column sum of the incoming column and 3x3 sum
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      cs_new[ch*CSUM_W +: CSUM_W] = CSUM_W'(up_px[ch*PIX_W +: PIX_W])
                                    + CSUM_W'(mid_px[ch*PIX_W +: PIX_W])
                                    + CSUM_W'(s1_px_r[ch*PIX_W +: PIX_W]);
      sum_all[ch*SUM_W +: SUM_W] = SUM_W'(s2_cs0_r[ch*CSUM_W +: CSUM_W])
                                   + SUM_W'(s2_cs1_r[ch*CSUM_W +: CSUM_W])
                                   + SUM_W'(s2_cs2_r[ch*CSUM_W +: CSUM_W]);
    end
  end

  // Divide by 9 through the reciprocal; border pixels take the center
  always_comb begin
    logic [PROD_W-1:0] prod;
    prod = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod = PROD_W'(s3_sum_r[ch*SUM_W +: SUM_W]) * PROD_W'(DIV9_RECIP);
      mean_px[ch*PIX_W +: PIX_W] = prod[DIV9_SHIFT +: PIX_W];
    end
    out_px_nxt = s3_int_r ? mean_px : s3_ctr_r;
  end

  // Control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cs1_r       <= '0;
      cs2_r       <= '0;
      c2mid_r     <= '0;
    end else begin
      if (q_ready) begin
        s1_valid_r <= q_valid;
      end
      if (s2_free) begin
        s2_valid_r <= s1_go && s1_flags_r.emit;
      end
      if (s3_free) begin
        s3_valid_r <= s2_valid_r;
      end
      if (out_en) begin
        out_valid_r <= s3_valid_r;
      end
      if (s1_go) begin
        cs1_r   <= cs2_r;
        cs2_r   <= cs_new;
        c2mid_r <= mid_px;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_px_r    <= q_px;
      s1_col_r   <= q_col;
      s1_flags_r <= q_flags;
      byp_r      <= s1_go && (s1_col_r == q_col);
      byp_word_r <= wr_word;
    end
    if (s2_free) begin
      s2_cs0_r  <= cs1_r;
      s2_cs1_r  <= cs2_r;
      s2_cs2_r  <= cs_new;
      s2_ctr_r  <= c2mid_r;
      s2_int_r  <= s1_flags_r.interior;
      s2_last_r <= s1_flags_r.last;
    end
    if (s3_free) begin
      s3_sum_r  <= sum_all;
      s3_ctr_r  <= s2_ctr_r;
      s3_int_r  <= s2_int_r;
      s3_last_r <= s2_last_r;
    end
    if (out_en) begin
      out_px_r   <= out_px_nxt;
      out_last_r <= s3_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_blue  = out_px_r[PIX_W-1:0];
  assign out_green = out_px_r[2*PIX_W-1:PIX_W];
  assign out_red   = out_px_r[3*PIX_W-1:2*PIX_W];
  assign out_last  = out_last_r;

endmodule

// File: rtl/box_filter_3x3_rgb_top.sv
// 3x3 box (mean) filter for a raster stream of 8-bit blue, green, red pixels.
// The block takes one request per clock unless out_ready stalls it, and
// delivers at most one result per clock; a request holds one pixel (opcode
// pixel) or is a flush tick. Each channel of an interior pixel is
// floor(sum of its 3x3 neighborhood / 9); pixels of the first and last rows
// and columns pass through unchanged. The result for a pixel appears after
// frame_width + 1 further requests and then passes the queue, the back-end
// stages and the output register. Flush ticks sent before the whole frame is
// in are consumed without effect; after the last pixel, frame_width + 1
// requests (flush or pixel, samples ignored) push out the frame tail, and the
// final result carries frame_last. The sustained rate is one request per cycle
// while the output is not stalled, set by the single line-store RAM that does
// one read and one write per cycle. The line store needs no clearing pass and
// the block is ready right after reset. Writing frame_width or frame_height
// (only while idle) restarts the frame. Depends on bfr_pkg, bfr_front,
// bfr_fifo, bfr_back, bfr_ram and the macros header box_filter_3x3_rgb_top_macros.svh.
`include "box_filter_3x3_rgb_top_macros.svh"

module box_filter_3x3_rgb_top
  import bfr_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [PIX_W-1:0]      in_blue_in,
  input  logic [PIX_W-1:0]      in_green_in,
  input  logic [PIX_W-1:0]      in_red_in,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_blue_out,
  output logic [PIX_W-1:0]      out_green_out,
  output logic [PIX_W-1:0]      out_red_out,
  output logic                  out_frame_last,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int FLG_W = $bits(bfr_flags_t);
  localparam int Q_W   = FLG_W + COL_W + RGB_W;

  logic            q_push, q_push_ready, q_pop_valid, q_pop_ready;
  logic [Q_W-1:0]  q_wr_data, q_rd_data;
  logic [RGB_W-1:0] f_px, b_px;
  logic [COL_W-1:0] f_col, b_col;
  bfr_flags_t      f_flags, b_flags;
  bfr_front_stat_t fstat;
  logic            flush_drop, cfg_hit;

  // Front end: counters and classification
  bfr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_blue   (in_blue_in),
    .in_green  (in_green_in),
    .in_red    (in_red_in),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_push),
    .q_ready   (q_push_ready),
    .q_px      (f_px),
    .q_col     (f_col),
    .q_flags   (f_flags),
    .stat      (fstat)
  );

  // Decoupling queue
  assign q_wr_data = {f_flags, f_col, f_px};

  bfr_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_push),
    .wr_ready (q_push_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_pop_valid),
    .rd_ready (q_pop_ready),
    .rd_data  (q_rd_data)
  );

  assign b_flags = q_rd_data[Q_W-1 -: FLG_W];
  assign b_col   = q_rd_data[RGB_W +: COL_W];
  assign b_px    = q_rd_data[RGB_W-1:0];

  // Back end: line store, window and arithmetic
  bfr_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_pop_valid),
    .q_ready   (q_pop_ready),
    .q_px      (b_px),
    .q_col     (b_col),
    .q_flags   (b_flags),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_blue  (out_blue_out),
    .out_green (out_green_out),
    .out_red   (out_red_out),
    .out_last  (out_frame_last)
  );

  // Checks
  assign flush_drop = in_valid && in_ready && (in_opcode == OP_FLUSH) && !fstat.draining;
  assign cfg_hit    = cfg_valid && cfg_ready
                      && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  `BFR_ASSERT_SAME(a_flush_dropped, flush_drop, !q_push, "mid-frame flush entered the queue")
  `BFR_ASSERT_NEXT(a_frame_restart, fstat.frame_done, !fstat.draining, "frame end not cleared")
  `BFR_ASSERT_NEXT(a_cfg_restart, cfg_hit, !fstat.draining, "config write did not restart frame")

endmodule
